@@ design/argon2_block_compress_assert.svh @@
// Assertion macros for the Argon2 block compression core.
// Depends on nothing; included by the top level.
`ifndef ARGON2_BLOCK_COMPRESS_ASSERT_SVH
`define ARGON2_BLOCK_COMPRESS_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define AB_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define AB_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AB_ASSERT_IMP(label, clk, rstn, ante, cons)
`define AB_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

@@ design/argon2_pkg.sv @@
// Shared types, constants and mixing helpers for the Argon2 compression core.
// Depends on nothing.
`default_nettype none
package argon2_pkg;
    localparam int BLOCK_WORDS_DEF = 128;
    localparam int ROT_A = 32;
    localparam int ROT_B = 24;
    localparam int ROT_C = 16;
    localparam int ROT_D = 63;

    typedef enum logic [2:0] {
        ST_LOAD, ST_COPY, ST_RD, ST_MIX, ST_WR, ST_OUT
    } state_t;

    // Product of the low halves for the multiply-augmented add: a + b + 2*lo(a)*lo(b).
    function automatic logic [63:0] mul_lo(input logic [63:0] x, input logic [63:0] y);
        mul_lo = x[31:0] * y[31:0];
    endfunction

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction
endpackage
`default_nettype wire

@@ design/argon2_mix.sv @@
// Shared mixing unit: one of the four add/xor/rotate steps of the Argon2 (BlaMka) G
// function per call (multiply registered, then add/xor/rotate). Uses argon2_pkg.
`default_nettype none
module argon2_mix
    import argon2_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        start,
    input  wire logic [1:0]  phase,
    input  wire logic [63:0] in_x,
    input  wire logic [63:0] in_y,
    input  wire logic [63:0] in_z,
    output logic      [63:0] out_x,
    output logic      [63:0] out_z
);
    logic [63:0] prod_reg;
    logic [63:0] x_reg, y_reg, z_reg;
    logic [1:0]  ph_reg;
    logic [63:0] sum, t;

    // Register the product
    always_ff @(posedge aclk) begin
        if (start) begin
            prod_reg <= mul_lo(in_x, in_y);
            x_reg <= in_x;
            y_reg <= in_y;
            z_reg <= in_z;
            ph_reg <= phase;
        end
    end

    // x = x + y + 2p, z = rot(z ^ x)
    always_comb begin
        sum = x_reg + y_reg + {prod_reg[62:0], 1'b0};
        t = z_reg ^ sum;
        case (ph_reg)
            2'd0: out_z = rotr(t, ROT_A);
            2'd1: out_z = rotr(t, ROT_B);
            2'd2: out_z = rotr(t, ROT_C);
            default: out_z = rotr(t, ROT_D);
        endcase
        out_x = sum;
    end
endmodule
`default_nettype wire

@@ design/argon2_block_compress.sv @@
// Argon2 compression G over 128-word blocks.
// Sequence: words load while s_ready is high; after the last word, a copy into the
// working memory, then 16 permutations x (16 word reads + 8 G + 16 writes), then the
// output phase (one word read per cycle unless the result side stalls, two per pair).
// s_ready is high only in the load state, so a new block waits until the output phase ends.
// Reset: synchronous active low; clears control and accumulate mode, not memories.
`default_nettype none
module argon2_block_compress
    import argon2_pkg::*;
#(
    parameter int BLOCK_WORDS = BLOCK_WORDS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [63:0] s_prev_word,
    input  wire logic [63:0] s_ref_word,
    input  wire logic [63:0] s_old_word,
    input  wire logic        s_last_word,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [63:0] m_even_word,
    output logic      [63:0] m_odd_word,
    output logic             m_final_pair
);
    localparam int AW = $clog2(BLOCK_WORDS);

    logic [63:0] xor_mem  [BLOCK_WORDS];
    logic [63:0] work_mem [BLOCK_WORDS];
    logic [63:0] old_mem  [BLOCK_WORDS];

    state_t state_reg, state_next;
    logic [AW-1:0] load_count_reg;
    logic          acc_reg;
    logic [AW:0]   cnt_reg, cnt_next;      // general sweep counter
    logic [4:0]    perm_reg, perm_next;    // 0..7 rows, 8..15 columns
    logic [3:0]    g_reg, g_next;          // G index within round
    logic [2:0]    sub_reg, sub_next;      // step within G
    logic [63:0]   v_reg [16];
    logic [63:0]   xrd_reg, wrd_reg, ord_reg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          wr_en;
    logic [63:0]   wr_data;
    logic          rd_vld_reg;
    logic [3:0]    rd_idx_reg;
    logic          rd_odd_reg;
    logic [63:0]   even_reg;
    logic          m_valid_reg;

    // Mixing unit
    logic [3:0]  ia, ib, ic, id, ix, iy, iz;
    logic [1:0]  ph;
    logic [63:0] mx_x, mx_z;
    logic        mx_start;

    function automatic logic [AW-1:0] perm_addr(input logic [4:0] p, input logic [3:0] k);
        logic [6:0] a;
        if (!p[3]) a = {p[2:0], k};
        else       a = {k[3:1], p[2:0], k[0]};
        perm_addr = a[AW-1:0];
    endfunction

    // Select G lanes
    always_comb begin
        case (g_reg[2:0])
            3'd0: begin ia = 4'd0; ib = 4'd4; ic = 4'd8;  id = 4'd12; end
            3'd1: begin ia = 4'd1; ib = 4'd5; ic = 4'd9;  id = 4'd13; end
            3'd2: begin ia = 4'd2; ib = 4'd6; ic = 4'd10; id = 4'd14; end
            3'd3: begin ia = 4'd3; ib = 4'd7; ic = 4'd11; id = 4'd15; end
            3'd4: begin ia = 4'd0; ib = 4'd5; ic = 4'd10; id = 4'd15; end
            3'd5: begin ia = 4'd1; ib = 4'd6; ic = 4'd11; id = 4'd12; end
            3'd6: begin ia = 4'd2; ib = 4'd7; ic = 4'd8;  id = 4'd13; end
            default: begin ia = 4'd3; ib = 4'd4; ic = 4'd9; id = 4'd14; end
        endcase
        // sub_reg[2:1] is the step within G; a,b,d / c,d,b / a,b,d / c,d,b
        ph = sub_reg[2:1];
        if (!sub_reg[1]) begin ix = ia; iy = ib; iz = id; end
        else             begin ix = ic; iy = id; iz = ib; end
    end
    assign mx_start = (state_reg == ST_MIX) && !sub_reg[0];

    argon2_mix u_mix (
        .aclk(aclk), .start(mx_start), .phase(ph),
        .in_x(v_reg[ix]), .in_y(v_reg[iy]), .in_z(v_reg[iz]),
        .out_x(mx_x), .out_z(mx_z)
    );

    logic out_adv;
    assign out_adv = !m_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        perm_next = perm_reg;
        g_next = g_reg;
        sub_next = sub_reg;
        case (state_reg)
            ST_LOAD: begin
                cnt_next = '0;
                if (s_valid && s_last_word) state_next = ST_COPY;
            end
            ST_COPY: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (AW+1)'(BLOCK_WORDS - 1)) begin
                    state_next = ST_RD; cnt_next = '0; perm_next = '0;
                end
            end
            ST_RD: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (AW+1)'(16)) begin
                    state_next = ST_MIX; g_next = '0; sub_next = '0;
                end
            end
            ST_MIX: begin
                sub_next = sub_reg + 1'b1;
                if (sub_reg == 3'd7) begin
                    g_next = g_reg + 1'b1;
                    if (g_reg == 4'd7) begin state_next = ST_WR; cnt_next = '0; end
                end
            end
            ST_WR: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (AW+1)'(15)) begin
                    cnt_next = '0;
                    perm_next = perm_reg + 1'b1;
                    state_next = (perm_reg == 5'd15) ? ST_OUT : ST_RD;
                end
            end
            ST_OUT: begin
                // cnt counts word reads issued; pair out on odd read data
                if (!(rd_vld_reg && rd_odd_reg && !out_adv) &&
                    cnt_reg != (AW+1)'(BLOCK_WORDS))
                    cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (AW+1)'(BLOCK_WORDS) && !rd_vld_reg && out_adv)
                    state_next = ST_LOAD;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // Read address and write port
    logic out_hold;
    assign out_hold = rd_vld_reg && rd_odd_reg && !out_adv;
    always_comb begin
        rd_addr = cnt_reg[AW-1:0];
        wr_en = 1'b0;
        wr_addr = cnt_reg[AW-1:0];
        wr_data = xrd_reg;
        case (state_reg)
            ST_COPY: ;
            ST_RD:   rd_addr = perm_addr(perm_reg, cnt_reg[3:0]);
            ST_WR: begin
                wr_en = 1'b1;
                wr_addr = perm_addr(perm_reg, cnt_reg[3:0]);
                wr_data = v_reg[cnt_reg[3:0]];
            end
            ST_OUT:  if (out_hold) rd_addr = cnt_reg[AW-1:0] - 1'b1;
            default: ;
        endcase
    end

    // Copy: each word is written in the cycle after its read
    logic          cp_vld_reg;
    logic [AW-1:0] cp_addr_reg;
    always_ff @(posedge aclk) begin
        cp_vld_reg <= (state_reg == ST_COPY);
        cp_addr_reg <= cnt_reg[AW-1:0];
    end

    // Memories
    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOAD && s_valid) begin
            xor_mem[load_count_reg] <= s_prev_word ^ s_ref_word;
            old_mem[load_count_reg] <= s_old_word;
        end
        xrd_reg <= xor_mem[rd_addr];
        ord_reg <= old_mem[rd_addr];
        wrd_reg <= work_mem[rd_addr];
        if (wr_en) work_mem[wr_addr] <= wr_data;
        else if (cp_vld_reg) work_mem[cp_addr_reg] <= xrd_reg;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            load_count_reg <= '0;
            acc_reg <= 1'b0;
            cnt_reg <= '0;
            perm_reg <= '0;
            g_reg <= '0;
            sub_reg <= '0;
            rd_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            perm_reg <= perm_next;
            g_reg <= g_next;
            sub_reg <= sub_next;
            if (cfg_we) acc_reg <= cfg_wdata;
            if (state_reg == ST_LOAD && s_valid)
                load_count_reg <= s_last_word ? '0 : load_count_reg + 1'b1;
            if (state_reg == ST_OUT) begin
                if (!out_hold)
                    rd_vld_reg <= (cnt_reg != (AW+1)'(BLOCK_WORDS));
                if (out_adv) m_valid_reg <= rd_vld_reg && rd_odd_reg;
            end else begin
                rd_vld_reg <= 1'b0;
                if (m_ready) m_valid_reg <= 1'b0;
            end
        end
    end

    // Gather, mix and output payload
    always_ff @(posedge aclk) begin
        rd_idx_reg <= cnt_reg[3:0];
        if (!out_hold) rd_odd_reg <= cnt_reg[0];
        if (state_reg == ST_RD && cnt_reg != '0) v_reg[rd_idx_reg] <= wrd_reg;
        if (state_reg == ST_MIX && sub_reg[0]) begin
            v_reg[ix] <= mx_x;
            v_reg[iz] <= mx_z;
        end
        if (state_reg == ST_OUT && rd_vld_reg && !rd_odd_reg && !out_hold)
            even_reg <= xrd_reg ^ wrd_reg ^ (acc_reg ? ord_reg : 64'd0);
        if (state_reg == ST_OUT && rd_vld_reg && rd_odd_reg && out_adv) begin
            m_even_word <= even_reg;
            m_odd_word <= xrd_reg ^ wrd_reg ^ (acc_reg ? ord_reg : 64'd0);
            m_final_pair <= (cnt_reg == (AW+1)'(BLOCK_WORDS));
        end
    end

    assign s_ready = (state_reg == ST_LOAD);
    assign m_valid = m_valid_reg;

`include "argon2_block_compress_assert.svh"
    `AB_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, state_reg != ST_LOAD, !s_ready)
    `AB_ASSERT_NEXT(a_last_starts, aclk, aresetn, s_valid && s_ready && s_last_word, state_reg == ST_COPY)
    `AB_ASSERT_IMP(a_out_only_out, aclk, aresetn, rd_vld_reg, state_reg == ST_OUT)
endmodule
`default_nettype wire

@@ test/argon2_block_compress_check.sv @@
// Checker for the Argon2 block compression core: watches the input, result and
// configuration ports, predicts every result pair and compares. Uses argon2_pkg.
`timescale 1ns / 100ps
module argon2_block_compress_check
    import argon2_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [63:0] s_prev_word,
    input  wire logic [63:0] s_ref_word,
    input  wire logic [63:0] s_old_word,
    input  wire logic        s_last_word,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [63:0] m_even_word,
    input  wire logic [63:0] m_odd_word,
    input  wire logic        m_final_pair,
    output int               fail_count,
    output int               pairs_waiting,
    output int               pairs_seen
);
    typedef logic [63:0] lane_t [16];
    typedef struct packed {
        logic [63:0] even_w;
        logic [63:0] odd_w;
        logic        fin;
    } pair_t;

    pair_t       pair_q[$];
    logic [63:0] r_mem   [BLOCK_WORDS_DEF];
    logic [63:0] old_mem [BLOCK_WORDS_DEF];
    logic [6:0]  word_pos;
    logic        acc_mode;

    function automatic logic [63:0] fma64(logic [63:0] x, logic [63:0] y);
        logic [63:0] prod;
        prod = {32'd0, x[31:0]} * {32'd0, y[31:0]};
        return x + y + (prod << 1);
    endfunction

    function automatic logic [63:0] ror64(logic [63:0] x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic lane_t quarter_mix(lane_t v, int a, int b, int c, int d);
        v[a] = fma64(v[a], v[b]);
        v[d] = ror64(v[d] ^ v[a], ROT_A);
        v[c] = fma64(v[c], v[d]);
        v[b] = ror64(v[b] ^ v[c], ROT_B);
        v[a] = fma64(v[a], v[b]);
        v[d] = ror64(v[d] ^ v[a], ROT_C);
        v[c] = fma64(v[c], v[d]);
        v[b] = ror64(v[b] ^ v[c], ROT_D);
        return v;
    endfunction

    function automatic lane_t perm_round(lane_t v);
        v = quarter_mix(v, 0, 4, 8, 12);
        v = quarter_mix(v, 1, 5, 9, 13);
        v = quarter_mix(v, 2, 6, 10, 14);
        v = quarter_mix(v, 3, 7, 11, 15);
        v = quarter_mix(v, 0, 5, 10, 15);
        v = quarter_mix(v, 1, 6, 11, 12);
        v = quarter_mix(v, 2, 7, 8, 13);
        v = quarter_mix(v, 3, 4, 9, 14);
        return v;
    endfunction

    // Permute rows then columns of R, queue the 64 output pairs
    task automatic predict_block();
        logic [63:0] w [BLOCK_WORDS_DEF];
        lane_t       v;
        pair_t       p;
        int          i;
        int          k;
        for (i = 0; i < BLOCK_WORDS_DEF; i++) w[i] = r_mem[i];
        for (i = 0; i < 8; i++) begin
            for (k = 0; k < 16; k++) v[k] = w[16 * i + k];
            v = perm_round(v);
            for (k = 0; k < 16; k++) w[16 * i + k] = v[k];
        end
        for (i = 0; i < 8; i++) begin
            for (k = 0; k < 16; k++) v[k] = w[16 * (k >> 1) + 2 * i + (k & 1)];
            v = perm_round(v);
            for (k = 0; k < 16; k++) w[16 * (k >> 1) + 2 * i + (k & 1)] = v[k];
        end
        for (k = 0; k < BLOCK_WORDS_DEF / 2; k++) begin
            p.even_w = r_mem[2 * k] ^ w[2 * k];
            p.odd_w  = r_mem[2 * k + 1] ^ w[2 * k + 1];
            if (acc_mode) begin
                p.even_w ^= old_mem[2 * k];
                p.odd_w  ^= old_mem[2 * k + 1];
            end
            p.fin = (k == BLOCK_WORDS_DEF / 2 - 1);
            pair_q.push_back(p);
        end
    endtask

    initial begin
        fail_count    = 0;
        pairs_waiting = 0;
        pairs_seen    = 0;
    end

    always @(posedge aclk) begin
        pair_t want;
        if (!aresetn) begin
            word_pos = '0;
            acc_mode = 1'b0;
        end else begin
            if (cfg_we) acc_mode = cfg_wdata;
            // Compare each result transfer with the oldest prediction
            if (m_valid && m_ready) begin
                pairs_seen++;
                if (pair_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result pair even=%h odd=%h", m_even_word,
                                 m_odd_word);
                end else begin
                    want = pair_q.pop_front();
                    if (m_even_word !== want.even_w || m_odd_word !== want.odd_w ||
                        m_final_pair !== want.fin) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("pair %0d: expected %h %h %b, got %h %h %b",
                                     pairs_seen - 1, want.even_w, want.odd_w, want.fin,
                                     m_even_word, m_odd_word, m_final_pair);
                    end
                end
            end
            // Store input transfer, predict on the last word
            if (s_valid && s_ready) begin
                r_mem[word_pos]   = s_prev_word ^ s_ref_word;
                old_mem[word_pos] = s_old_word;
                if (s_last_word) begin
                    predict_block();
                    word_pos = '0;
                end else begin
                    word_pos = word_pos + 7'd1;
                end
            end
        end
        pairs_waiting = pair_q.size();
    end
endmodule

@@ test/argon2_block_compress_test.sv @@
// Testbench top for argon2_block_compress: drives blocks and mode changes,
// varies both handshakes and gives the verdict. Needs argon2_block_compress_check.
`timescale 1ns / 100ps
module argon2_block_compress_test;
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_prev_word = '0;
    logic [63:0] s_ref_word = '0;
    logic [63:0] s_old_word = '0;
    logic        s_last_word = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_even_word;
    logic [63:0] m_odd_word;
    logic        m_final_pair;
    int          fail_count;
    int          pairs_waiting;
    int          pairs_seen;
    int          words_sent = 0;
    int          blocks_sent = 0;
    bit          held_off = 1'b0;

    argon2_block_compress u_top (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_prev_word(s_prev_word),
        .s_ref_word(s_ref_word), .s_old_word(s_old_word), .s_last_word(s_last_word),
        .m_valid(m_valid), .m_ready(m_ready), .m_even_word(m_even_word),
        .m_odd_word(m_odd_word), .m_final_pair(m_final_pair)
    );

    argon2_block_compress_check u_check (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_prev_word(s_prev_word),
        .s_ref_word(s_ref_word), .s_old_word(s_old_word), .s_last_word(s_last_word),
        .m_valid(m_valid), .m_ready(m_ready), .m_even_word(m_even_word),
        .m_odd_word(m_odd_word), .m_final_pair(m_final_pair),
        .fail_count(fail_count), .pairs_waiting(pairs_waiting), .pairs_seen(pairs_seen)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Offer one word after a random gap and hold it until the transfer
    task automatic put_word(logic [63:0] pw, logic [63:0] rw, logic [63:0] ow,
                            logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_prev_word <= pw;
        s_ref_word  <= rw;
        s_old_word  <= ow;
        s_last_word <= last;
        s_valid     <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        words_sent++;
    endtask

    // Drain all results, let the core settle, then write the mode
    task automatic set_mode(logic mode);
        while (pairs_waiting != 0) @(negedge aclk);
        s_valid <= 1'b0;
        repeat (40) @(negedge aclk);
        cfg_wdata <= mode;
        cfg_we    <= 1'b1;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [63:0] edge_word(int i, int sel);
        case ((i + sel) % 4)
            0: return 64'h0;
            1: return '1;
            2: return 64'hAAAA_AAAA_AAAA_AAAA;
            default: return rand64();
        endcase
    endfunction

    // Result side: random stalls, and one long hold-off while a block drains
    initial begin
        int run;
        forever begin
            @(negedge aclk);
            if (!held_off && blocks_sent >= 2 && pairs_waiting > 0 && pairs_seen >= 64) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (3000) @(negedge aclk);
            end
            run = pick_gap();
            if (run > 0) begin
                m_ready <= 1'b0;
                repeat (run) @(negedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
    end

    // Stimulus
    initial begin
        int len;
        int i;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        set_mode(1'b0);
        // Overlong block of mostly extreme words: fills every entry, then wraps
        for (i = 0; i < 131; i++)
            put_word(edge_word(i, 0), edge_word(i, 1), edge_word(i, 2), i == 130);
        blocks_sent++;
        set_mode(1'b1);
        // Short random blocks over the stored words
        while (words_sent < 176) begin
            if (blocks_sent % 4 == 0) set_mode((blocks_sent % 8 == 0) ? 1'b0 : 1'b1);
            len = $urandom_range(1, 12);
            for (i = 0; i < len; i++)
                put_word(rand64(), rand64(), rand64(), i == len - 1);
            blocks_sent++;
        end
        s_valid <= 1'b0;
        while (pairs_waiting != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
        $display("covered %0d words in %0d blocks, %0d result pairs, both modes",
                 words_sent, blocks_sent, pairs_seen);
        if (fail_count == 0)
            $display("argon2_block_compress_test: clean");
        else
            $display("argon2_block_compress_test: errors");
        $finish;
    end

    initial begin
        #8ms;
        $display("argon2_block_compress_test: errors");
        $finish;
    end
endmodule
